/* hw/rtl/nodj_pkg.sv */
// ----------------------------------------------------------------------------
// nodj_pkg: shared types and constants
// Field widths, the nanosecond scale factor and the record that passes from
// the front end to the back end through the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nodj_pkg;

	// Field widths
	localparam int TS_W  = 64;
	localparam int NS_W  = 63;
	localparam int JIT_W = 56;

	// Magnitude of a signed sum of four timestamps, in 2^-32 s units
	localparam int MAG_W = 65;

	// Stream data widths (fields packed, padded to whole bytes)
	localparam int IN_TDATA_W  = 4 * TS_W;
	localparam int OUT_TDATA_W = ((3 * NS_W + JIT_W + 7) / 8) * 8;

	// Nanoseconds per second
	localparam logic [29:0] NS_PER_S = 30'd1000000000;

	// Saturation limits
	localparam logic signed [NS_W-1:0] NS_POS_MAX = {1'b0, {(NS_W-1){1'b1}}};
	localparam logic signed [NS_W-1:0] NS_NEG_MIN = {1'b1, {(NS_W-1){1'b0}}};
	localparam logic [JIT_W-1:0]       JIT_MAX    = {JIT_W{1'b1}};

	// Classified exchange: sign and magnitude of the offset and delay sums
	typedef struct packed {
		logic             off_neg;
		logic [MAG_W-1:0] off_mag;
		logic             del_neg;
		logic [MAG_W-1:0] del_mag;
	} item_t;

endpackage

`default_nettype wire

/* hw/rtl/nodj_ram.sv */
// ----------------------------------------------------------------------------
// nodj_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nodj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/nodj_front.sv */
// ----------------------------------------------------------------------------
// nodj_front: exchange intake and classification
// Takes the four timestamps, forms the offset and delay sums in 2^-32 s
// units and splits them into sign and magnitude for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nodj_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [nodj_pkg::TS_W-1:0]     client_send_time,
	input  wire  [nodj_pkg::TS_W-1:0]     server_receive_time,
	input  wire  [nodj_pkg::TS_W-1:0]     server_transmit_time,
	input  wire  [nodj_pkg::TS_W-1:0]     client_receive_time,
	output logic                          push,
	input  wire                           push_ready,
	output nodj_pkg::item_t               push_item
);

	localparam int DW = nodj_pkg::TS_W + 1;

	logic                 v_s1_q;
	logic signed [DW-1:0] d_a_s1;
	logic signed [DW-1:0] d_b_s1;
	logic signed [DW:0]   u_off;
	logic signed [DW:0]   u_del;
	logic        [DW:0]   m_off;
	logic        [DW:0]   m_del;
	logic                 accept;

	assign in_ready = !v_s1_q || push_ready;
	assign accept   = in_valid && in_ready;
	assign push     = v_s1_q;

	// Stage 1: pairwise differences T2-T1 and T3-T4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (in_ready) begin
			v_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_a_s1 <= $signed({1'b0, server_receive_time}) - $signed({1'b0, client_send_time});
			d_b_s1 <= $signed({1'b0, server_transmit_time}) - $signed({1'b0, client_receive_time});
		end
	end

	// Offset sum is a+b, delay sum is a-b; then sign and magnitude
	always_comb begin
		u_off = {d_a_s1[DW-1], d_a_s1} + {d_b_s1[DW-1], d_b_s1};
		u_del = {d_a_s1[DW-1], d_a_s1} - {d_b_s1[DW-1], d_b_s1};
		m_off = u_off[DW] ? -u_off : u_off;
		m_del = u_del[DW] ? -u_del : u_del;
		push_item.off_neg = u_off[DW];
		push_item.off_mag = m_off[nodj_pkg::MAG_W-1:0];
		push_item.del_neg = u_del[DW];
		push_item.del_mag = m_del[nodj_pkg::MAG_W-1:0];
	end

endmodule

`default_nettype wire

/* hw/rtl/nodj_queue.sv */
// ----------------------------------------------------------------------------
// nodj_queue: two-entry queue between front and back end
// Holds classified exchanges so that either side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nodj_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              push_ready,
	input  nodj_pkg::item_t   push_item,
	output logic              pop_valid,
	input  wire               pop,
	output nodj_pkg::item_t   pop_item
);

	nodj_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/nodj_back.sv */
// ----------------------------------------------------------------------------
// nodj_back: nanosecond scaling, delay-change window and jitter divider
// Scales both sums to ns with a shared 33x30 multiplier, saturates, updates
// the change window and divides its total by the fill count bit-serially.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nodj_back #(
	parameter int WINDOW_DEPTH = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                pop_valid,
	output logic                               pop,
	input  nodj_pkg::item_t                    pop_item,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [nodj_pkg::NS_W-1:0]   ofs_nsec,
	output logic signed [nodj_pkg::NS_W-1:0]   dly_nsec,
	output logic        [nodj_pkg::JIT_W-1:0]  jit_nsec,
	output logic signed [nodj_pkg::NS_W-1:0]   dlt_nsec
);

	localparam int NS_W   = nodj_pkg::NS_W;
	localparam int JIT_W  = nodj_pkg::JIT_W;
	localparam int PW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int TW     = JIT_W + $clog2(WINDOW_DEPTH);
	localparam int DIV_CW = $clog2(TW + 1);
	localparam int PROD_W = 63;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SAT  = 7'b0000100,
		ST_UPD  = 7'b0001000,
		ST_WIN  = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t                   state_q;
	nodj_pkg::item_t          item_q;
	logic [2:0]               mul_cnt_q;
	logic [PROD_W-1:0]        prod_s1;
	logic [63:0]              m_off_q;
	logic [63:0]              m_del_q;
	logic signed [NS_W-1:0]   offset_q;
	logic signed [NS_W-1:0]   delay_q;
	logic signed [NS_W-1:0]   delta_q;
	logic signed [NS_W-1:0]   prev_q;
	logic [JIT_W-1:0]         change_q;
	logic                     win_q;
	logic [PW-1:0]            pos_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [TW-1:0]            total_q;
	logic [TW-1:0]            dvd_q;
	logic [CNT_W-1:0]         rem_q;
	logic [DIV_CW-1:0]        div_cnt_q;
	logic [JIT_W-1:0]         jitter_q;
	logic                     out_valid_q;

	logic [32:0]              mul_op;
	logic [JIT_W-1:0]         ram_rdata;
	logic [JIT_W-1:0]         old_change;
	logic [TW-1:0]            total_nxt;
	logic [CNT_W-1:0]         cnt_nxt;
	logic                     ram_we;
	logic signed [NS_W:0]     delta_sum;
	logic signed [NS_W:0]     diff;
	logic [NS_W:0]            diff_mag;
	logic [CNT_W:0]           rem_sh;
	logic                     rem_ge;
	logic [CNT_W:0]           rem_sub;
	logic                     load_out;

	// Sign and magnitude to saturated two's complement ns
	function automatic logic signed [NS_W-1:0] sat_ns(input logic neg, input logic [63:0] m);
		logic signed [NS_W-1:0] r;
		if (m[63:62] != 2'b00) begin
			r = neg ? nodj_pkg::NS_NEG_MIN : nodj_pkg::NS_POS_MAX;
		end else begin
			r = neg ? -$signed(m[NS_W-1:0]) : $signed(m[NS_W-1:0]);
		end
		return r;
	endfunction

	assign pop       = (state_q == ST_IDLE) && pop_valid;
	assign out_valid = out_valid_q;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Multiplier operand: offset low, offset high, delay low, delay high
	always_comb begin
		case (mul_cnt_q[1:0])
			2'd0:    mul_op = {1'b0, item_q.off_mag[31:0]};
			2'd1:    mul_op = item_q.off_mag[nodj_pkg::MAG_W-1:32];
			2'd2:    mul_op = {1'b0, item_q.del_mag[31:0]};
			default: mul_op = item_q.del_mag[nodj_pkg::MAG_W-1:32];
		endcase
	end

	// Delta, delay change and window update arithmetic
	always_comb begin
		delta_sum  = {offset_q[NS_W-1], offset_q} + {delay_q[NS_W-1], delay_q};
		diff       = {delay_q[NS_W-1], delay_q} - {prev_q[NS_W-1], prev_q};
		diff_mag   = diff[NS_W] ? -diff : diff;
		old_change = (cnt_q == CNT_W'(WINDOW_DEPTH)) ? ram_rdata : '0;
		total_nxt  = total_q - TW'(old_change) + TW'(change_q);
		cnt_nxt    = (cnt_q == CNT_W'(WINDOW_DEPTH)) ? cnt_q : cnt_q + CNT_W'(1);
		ram_we     = (state_q == ST_WIN) && win_q;
		rem_sh     = {rem_q, dvd_q[TW-1]};
		rem_ge     = rem_sh >= {1'b0, cnt_q};
		rem_sub    = rem_sh - {1'b0, cnt_q};
	end

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_cnt_q   <= '0;
			div_cnt_q   <= '0;
			prev_q      <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			jitter_q    <= '0;
			win_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						mul_cnt_q <= '0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 3'd1;
					if (mul_cnt_q == 3'd4) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					win_q   <= !prev_q[NS_W-1] && (prev_q != '0);
					state_q <= ST_WIN;
				end
				ST_WIN: begin
					prev_q <= delay_q;
					if (win_q) begin
						total_q   <= total_nxt;
						cnt_q     <= cnt_nxt;
						pos_q     <= (pos_q == PW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + PW'(1);
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CW'(1);
					if (div_cnt_q == DIV_CW'(TW - 1)) begin
						jitter_q <= {dvd_q[JIT_W-2:0], rem_ge};
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_item;
		end
		// Partial product, then fold into the ns magnitude
		if (state_q == ST_MUL) begin
			prod_s1 <= PROD_W'(mul_op) * PROD_W'(nodj_pkg::NS_PER_S);
			case (mul_cnt_q)
				3'd1:    m_off_q <= {34'd0, prod_s1[61:32]};
				3'd2:    m_off_q <= m_off_q + {1'b0, prod_s1};
				3'd3:    m_del_q <= {34'd0, prod_s1[61:32]};
				3'd4:    m_del_q <= m_del_q + {1'b0, prod_s1};
				default: m_del_q <= m_del_q;
			endcase
		end
		if (state_q == ST_SAT) begin
			offset_q <= sat_ns(item_q.off_neg, m_off_q >> 1);
			delay_q  <= sat_ns(item_q.del_neg, m_del_q);
		end
		if (state_q == ST_UPD) begin
			if (delta_sum[NS_W] != delta_sum[NS_W-1]) begin
				delta_q <= delta_sum[NS_W] ? nodj_pkg::NS_NEG_MIN : nodj_pkg::NS_POS_MAX;
			end else begin
				delta_q <= delta_sum[NS_W-1:0];
			end
			change_q <= (diff_mag[NS_W:JIT_W] != '0) ? nodj_pkg::JIT_MAX : diff_mag[JIT_W-1:0];
		end
		// Restoring division of the window total by the fill count
		if (state_q == ST_WIN) begin
			dvd_q <= total_nxt;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[TW-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
		// Output transaction register, held while stalled
		if (load_out) begin
			ofs_nsec <= offset_q;
			dly_nsec <= delay_q;
			jit_nsec <= jitter_q;
			dlt_nsec <= delta_q;
		end
	end

	// Delay-change window; entries not yet written read as zero via cnt_q
	nodj_ram #(
		.WIDTH (JIT_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (change_q),
		.re    (pop),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

/* hw/rtl/ntp_offset_delay_jitter.sv */
// ----------------------------------------------------------------------------
// ntp_offset_delay_jitter: time-sync exchange evaluator
// Computes clock offset, round-trip delay, delta and delay jitter in ns
// from one exchange of four 32.32 timestamps.
// ----------------------------------------------------------------------------
//  channel   dir   width  fields (lowest bit first)
//  s_axis    in    256    client_send_time, server_receive_time,
//                         server_transmit_time, client_receive_time
//  m_axis    out   248    ofs_nsec, dly_nsec, jit_nsec, dlt_nsec, pad
//
//  Front end: an accepted exchange is registered in stage 1, then pushed to
//  the queue. Back end: pops only when idle, never before the last exchange
//  is done; multiply, saturate, update and window steps, plus the bit-serial
//  divider for the window mean when the window is updated. arst_n clears all
//  control state and the window (fill count zero). A stalled output holds the
//  back end once the output register is full; the 2-entry queue still accepts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntp_offset_delay_jitter #(
	parameter int WINDOW_DEPTH = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// client_send_time, server_receive_time, server_transmit_time, client_receive_time
	input  wire  [nodj_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// ofs_nsec, dly_nsec, jit_nsec, dlt_nsec, zero pad
	output logic [nodj_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int TS_W = nodj_pkg::TS_W;
	localparam int PAD_W = nodj_pkg::OUT_TDATA_W - 3 * nodj_pkg::NS_W - nodj_pkg::JIT_W;

	logic                                push;
	logic                                push_ready;
	nodj_pkg::item_t                     push_item;
	logic                                pop_valid;
	logic                                pop;
	nodj_pkg::item_t                     pop_item;
	logic signed [nodj_pkg::NS_W-1:0]    ofs_nsec;
	logic signed [nodj_pkg::NS_W-1:0]    dly_nsec;
	logic        [nodj_pkg::JIT_W-1:0]   jit_nsec;
	logic signed [nodj_pkg::NS_W-1:0]    dlt_nsec;

	nodj_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (s_axis_tvalid),
		.in_ready             (s_axis_tready),
		.client_send_time     (s_axis_tdata[TS_W-1:0]),
		.server_receive_time  (s_axis_tdata[2*TS_W-1:TS_W]),
		.server_transmit_time (s_axis_tdata[3*TS_W-1:2*TS_W]),
		.client_receive_time  (s_axis_tdata[4*TS_W-1:3*TS_W]),
		.push                 (push),
		.push_ready           (push_ready),
		.push_item            (push_item)
	);

	nodj_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	nodj_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ofs_nsec  (ofs_nsec),
		.dly_nsec  (dly_nsec),
		.jit_nsec  (jit_nsec),
		.dlt_nsec  (dlt_nsec)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, dlt_nsec, jit_nsec, dly_nsec, ofs_nsec};

endmodule

`default_nettype wire

/* hw/rtl/nodj_checker.sv */
// ----------------------------------------------------------------------------
// nodj_checker: port-level assertions
// Watches the stream ports: no result without an accepted exchange pending,
// in-flight bound, delta consistency and output hold under stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nodj_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_axis_tvalid,
	input wire                              s_axis_tready,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [nodj_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam int          NS_W        = nodj_pkg::NS_W;
	localparam int          DELTA_LO    = 2 * NS_W + nodj_pkg::JIT_W;
	localparam logic [2:0]  MAX_PENDING = 3'd5;

	logic [2:0]            pend_q;
	logic                  in_acc;
	logic                  out_acc;
	logic signed [NS_W:0]  sum;
	logic [NS_W-1:0]       exp_delta;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// Expected delta from the offset and delay fields
	always_comb begin
		sum = $signed({m_axis_tdata[NS_W-1], m_axis_tdata[NS_W-1:0]})
			+ $signed({m_axis_tdata[2*NS_W-1], m_axis_tdata[2*NS_W-1:NS_W]});
		if (sum[NS_W] != sum[NS_W-1]) begin
			exp_delta = sum[NS_W] ? nodj_pkg::NS_NEG_MIN : nodj_pkg::NS_POS_MAX;
		end else begin
			exp_delta = sum[NS_W-1:0];
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 3'd0)
		else $error("result without a pending transaction");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= MAX_PENDING)
		else $error("too many transactions in flight");

	a_delta_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[DELTA_LO+NS_W-1:DELTA_LO] == exp_delta)
		else $error("delta does not match offset plus delay");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind ntp_offset_delay_jitter nodj_checker u_nodj_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* test/tb_ntp_offset_delay_jitter.sv */
// ----------------------------------------------------------------------------
// tb_ntp_offset_delay_jitter: self-checking bench for the exchange evaluator
// Sends four-timestamp exchanges into the input stream, predicts the offset,
// delay, jitter and delta of each one in a local model, and compares every
// output transaction with the oldest prediction under random idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ntp_offset_delay_jitter;

	localparam int TS_W        = nodj_pkg::TS_W;
	localparam int NS_W        = nodj_pkg::NS_W;
	localparam int JIT_W       = nodj_pkg::JIT_W;
	localparam int IN_TDATA_W  = nodj_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = nodj_pkg::OUT_TDATA_W;

	localparam int RING_DEPTH   = 8;
	localparam int RANDOM_ITEMS = 750;
	localparam int PHASE_LEN    = 40;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [TS_W-1:0]         TS_MAX      = {TS_W{1'b1}};
	localparam logic [99:0]             SAT_MAG     = 100'h4000_0000_0000_0000;
	localparam logic signed [63:0]      SUM_POS_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0]      SUM_NEG_MIN = -64'sh4000_0000_0000_0000;
	localparam logic [64:0]             CHANGE_CAP  = {9'd0, {JIT_W{1'b1}}};

	// Idle pattern applied to both sides, stepped by accepted count
	typedef enum logic [1:0] {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH_IDLE
	} idle_phase_t;

	// One output transaction, laid out as on m_axis_tdata without the pad
	typedef struct packed {
		logic [NS_W-1:0]  delta;
		logic [JIT_W-1:0] jitter;
		logic [NS_W-1:0]  delay;
		logic [NS_W-1:0]  offset;
	} result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// client_send_time, server_receive_time, server_transmit_time, client_receive_time
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// ofs_nsec, dly_nsec, jit_nsec, dlt_nsec, zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	logic [IN_TDATA_W-1:0] exchange_q[$];
	result_t               expected_results[$];

	idle_phase_t idle_phase = PH_STEADY;
	int          accepted_count = 0;
	int          checked_count  = 0;
	int          window_updates = 0;
	int          error_count    = 0;

	// Local copy of the jitter window
	logic signed [NS_W-1:0] prev_delay_ns = '0;
	logic [JIT_W-1:0]       change_ring[RING_DEPTH];
	int unsigned            ring_pos   = 0;
	int unsigned            ring_fill  = 0;
	logic [59:0]            ring_total = '0;
	logic [JIT_W-1:0]       held_jitter = '0;

	ntp_offset_delay_jitter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the stream hangs
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Signed 2^-32 s units to ns, truncated toward zero, saturated to 63 bits
	function automatic logic signed [NS_W-1:0] scale_to_ns(input logic signed [67:0] units,
			input bit halve);
		logic [67:0] mag;
		logic [99:0] ns;
		mag = (units < 0) ? -units : units;
		ns  = (100'(mag) * 100'(nodj_pkg::NS_PER_S)) >> 32;
		if (halve)
			ns = ns >> 1;
		if (ns >= SAT_MAG)
			return (units < 0) ? nodj_pkg::NS_NEG_MIN : nodj_pkg::NS_POS_MAX;
		if (units < 0)
			return -$signed(ns[NS_W-1:0]);
		return ns[NS_W-1:0];
	endfunction

	// Offset, delay, delta and window jitter for one exchange; updates the window
	function automatic result_t evaluate_exchange(input logic [IN_TDATA_W-1:0] x);
		logic signed [67:0]     t1, t2, t3, t4;
		logic signed [NS_W-1:0] off_ns, del_ns;
		logic signed [63:0]     sum;
		logic signed [64:0]     diff;
		logic [64:0]            change_raw;
		logic [JIT_W-1:0]       change;
		result_t                r;
		t1 = $signed({4'b0, x[0*TS_W +: TS_W]});
		t2 = $signed({4'b0, x[1*TS_W +: TS_W]});
		t3 = $signed({4'b0, x[2*TS_W +: TS_W]});
		t4 = $signed({4'b0, x[3*TS_W +: TS_W]});
		off_ns = scale_to_ns((t2 - t1) + (t3 - t4), 1'b1);
		del_ns = scale_to_ns((t4 - t1) - (t3 - t2), 1'b0);
		sum = {off_ns[NS_W-1], off_ns} + {del_ns[NS_W-1], del_ns};
		r.offset = off_ns;
		r.delay  = del_ns;
		if (sum > SUM_POS_MAX)
			r.delta = nodj_pkg::NS_POS_MAX;
		else if (sum < SUM_NEG_MIN)
			r.delta = nodj_pkg::NS_NEG_MIN;
		else
			r.delta = sum[NS_W-1:0];

		// window only moves when the previous delay was positive
		if (prev_delay_ns > 0) begin
			diff = {{2{del_ns[NS_W-1]}}, del_ns} - {{2{prev_delay_ns[NS_W-1]}}, prev_delay_ns};
			change_raw = (diff < 0) ? -diff : diff;
			change = (change_raw > CHANGE_CAP) ? nodj_pkg::JIT_MAX : change_raw[JIT_W-1:0];
			ring_total = ring_total - 60'(change_ring[ring_pos]) + 60'(change);
			change_ring[ring_pos] = change;
			ring_pos = (ring_pos + 1) % RING_DEPTH;
			if (ring_fill < RING_DEPTH)
				ring_fill++;
			held_jitter = 56'(ring_total / 60'(ring_fill));
			window_updates++;
		end
		prev_delay_ns = del_ns;
		r.jitter = held_jitter;
		return r;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_exchange(input logic [TS_W-1:0] t1,
			input logic [TS_W-1:0] t2, input logic [TS_W-1:0] t3, input logic [TS_W-1:0] t4);
		return {t4, t3, t2, t1};
	endfunction

	function automatic logic [TS_W-1:0] rand_ts();
		return {$urandom, $urandom};
	endfunction

	// Mostly plausible exchanges, plus negative delays, big jumps and raw noise
	function automatic logic [IN_TDATA_W-1:0] random_exchange();
		logic [TS_W-1:0] t1, t2, t3, t4, skew, d_fwd, d_back, hold;
		int unsigned     kind;
		int unsigned     pick;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			pick = $urandom_range(15);
			t1 = (pick == 0) ? '0 : (pick == 1) ? TS_MAX : rand_ts();
			t2 = (pick == 2) ? '0 : (pick == 3) ? TS_MAX : rand_ts();
			t3 = (pick == 4) ? '0 : (pick == 5) ? TS_MAX : rand_ts();
			t4 = (pick == 6) ? '0 : (pick == 7) ? TS_MAX : rand_ts();
			return pack_exchange(t1, t2, t3, t4);
		end
		t1     = rand_ts();
		skew   = rand_ts() >> $urandom_range(63, 20);
		if ($urandom_range(1))
			skew = -skew;
		d_fwd  = 64'($urandom) >> $urandom_range(31, 4);
		d_back = 64'($urandom) >> $urandom_range(31, 4);
		hold   = 64'($urandom) >> $urandom_range(31, 8);
		if (kind >= 80)
			d_fwd = rand_ts() >> $urandom_range(40, 4);
		else if (kind >= 70)
			d_back = -(d_fwd + (64'($urandom) >> $urandom_range(31, 8)) + 64'd1);
		t2 = t1 + skew + d_fwd;
		t3 = t2 + hold;
		t4 = t3 - skew + d_back;
		return pack_exchange(t1, t2, t3, t4);
	endfunction

	function automatic int unsigned send_idle_pct(input idle_phase_t ph);
		case (ph)
			PH_SEND_IDLE: return 75;
			PH_BOTH_IDLE: return 14;
			default:      return 0;
		endcase
	endfunction

	function automatic int unsigned recv_stall_pct(input idle_phase_t ph);
		case (ph)
			PH_RECV_STALL: return 75;
			PH_BOTH_IDLE:  return 14;
			default:       return 0;
		endcase
	endfunction

	// Input driver: predict on each accepted transaction, then load the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(evaluate_exchange(s_axis_tdata));
				accepted_count++;
				idle_phase <= idle_phase_t'((accepted_count / PHASE_LEN) % 4);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (exchange_q.size() != 0 && $urandom_range(99) >= send_idle_pct(idle_phase)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= exchange_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each accepted transaction with the oldest prediction
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (expected_results.size() == 0) begin
					$error("unexpected output transaction, nothing pending");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (got.offset !== want.offset) begin
						$error("ofs_nsec: expected %0d, got %0d",
							$signed(want.offset), $signed(got.offset));
						error_count++;
					end
					if (got.delay !== want.delay) begin
						$error("dly_nsec: expected %0d, got %0d",
							$signed(want.delay), $signed(got.delay));
						error_count++;
					end
					if (got.jitter !== want.jitter) begin
						$error("jit_nsec: expected %0d, got %0d", want.jitter, got.jitter);
						error_count++;
					end
					if (got.delta !== want.delta) begin
						$error("dlt_nsec: expected %0d, got %0d",
							$signed(want.delta), $signed(got.delta));
						error_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct(idle_phase));
		end
	end

	// Stimulus, drain and verdict
	initial begin
		logic [TS_W-1:0] base, t1, t2, t3;
		for (int i = 0; i < RING_DEPTH; i++)
			change_ring[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// zero and all-ones timestamps
		exchange_q.push_back(pack_exchange('0, '0, '0, '0));
		exchange_q.push_back(pack_exchange(TS_MAX, TS_MAX, TS_MAX, TS_MAX));
		// delay saturates high, then low; the change caps the window entry
		exchange_q.push_back(pack_exchange('0, TS_MAX, '0, TS_MAX));
		exchange_q.push_back(pack_exchange(TS_MAX, '0, TS_MAX, '0));
		// large offsets pushing delta into saturation both ways
		base = rand_ts();
		exchange_q.push_back(pack_exchange('0, TS_MAX, base, base));
		exchange_q.push_back(pack_exchange(TS_MAX, '0, base, base));
		// negative sums with a partial fraction and with an exact whole second
		exchange_q.push_back(pack_exchange(64'h1_0000_0001, '0, '0, '0));
		exchange_q.push_back(pack_exchange(64'h1_0000_0000, '0, '0, '0));
		// fraction borrow across a second boundary
		t1 = {32'd5, 32'hFFFF_FFFF};
		t2 = {32'd6, 32'h0};
		exchange_q.push_back(pack_exchange(t1, t2, t2 + 64'd1000, t2 + 64'd1000 + 64'h1000_0000));
		// client time wrapping past the top of the seconds field
		t1 = TS_MAX - 64'd1000;
		exchange_q.push_back(pack_exchange(t1, t1 + 64'd500, t1 + 64'd600, t1 + 64'd2000));
		// run of small positive delays: fills the window and wraps it
		base = {32'd3_900_000_000, 32'd0};
		for (int i = 0; i < 13; i++) begin
			t1 = base + (64'(i) << 32);
			t2 = t1 + 64'h10_0000 + 64'($urandom_range(4095));
			t3 = t2 + 64'h1_0000;
			exchange_q.push_back(pack_exchange(t1, t2, t3,
				t3 + 64'h10_0000 + 64'(i * 5000)));
		end

		for (int i = 0; i < RANDOM_ITEMS; i++)
			exchange_q.push_back(random_exchange());

		do
			@(negedge clk);
		while (exchange_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d exchanges, checked %0d results, %0d jitter window updates",
			accepted_count, checked_count, window_updates);
		$display("Covered saturation, wrapped timestamps, window wrap and idle/stall phases");
		if (error_count == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
